[sv/lcd_window_write_formatter_unit_macros.svh]
// ----------------------------------------------------------------------------
// LCD window write formatter - assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef LCD_WINDOW_WRITE_FORMATTER_UNIT_MACROS_SVH
`define LCD_WINDOW_WRITE_FORMATTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LWF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lwf assertion failed");
`define LWF_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lwf forbidden condition seen");
`else
`define LWF_ASSERT(label, prop)
`define LWF_ASSERT_NEVER(label, cond)
`endif

`endif

[sv/lwf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window write formatter - package
// Shared types, command codes and a helper function.
// ----------------------------------------------------------------------------
package lwf_pkg;

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic REG_COLUMN_OFFSET = 1'b0;
  localparam logic REG_ROW_OFFSET    = 1'b1;

  localparam logic [7:0] COL_OFFSET_RESET = 8'd24;
  localparam logic [7:0] ROW_OFFSET_RESET = 8'd20;

  localparam logic [7:0] CMD_COL_START   = 8'hF4;
  localparam logic [7:0] CMD_ROW_START   = 8'hF5;
  localparam logic [7:0] CMD_COL_END     = 8'hF6;
  localparam logic [7:0] CMD_ROW_END     = 8'hF7;
  localparam logic [7:0] CMD_WIN_ENABLE  = 8'hF8;
  localparam logic [7:0] CMD_COL_ADDR_HI = 8'h10;
  localparam logic [7:0] CMD_ROW_ADDR_LO = 8'h60;
  localparam logic [7:0] CMD_ROW_ADDR_HI = 8'h70;

  localparam int unsigned WIN_BYTES = 13;
  localparam int unsigned PIX_BYTES = 4;
  localparam int unsigned STEP_W    = 4;

  localparam logic [7:0] PAIR_MAP [4] = '{8'h00, 8'hF0, 8'h0F, 8'hFF};

  typedef struct packed {
    logic       kind;
    logic [8:0] col;
    logic [7:0] top;
    logic [7:0] right;
    logic [7:0] bottom;
    logic [7:0] y;
    logic [7:0] pix;
  } lwf_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lwf_q_stat_t;

  // x / 3 for 8-bit x by reciprocal multiply
  function automatic logic [6:0] div3(input logic [7:0] x);
    logic [15:0] p;
    p = {8'd0, x} * 16'd171;
    return p[15:9];
  endfunction

endpackage

[sv/lwf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window write formatter - front end
// Accepts items, classifies them and precomputes window boundaries.
// ----------------------------------------------------------------------------
module lwf_front (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic [7:0]          col_offset_i,
  input  logic [7:0]          row_offset_i,
  input  lwf_pkg::lwf_q_stat_t q_stat_i,
  output logic                push_o,
  output lwf_pkg::lwf_job_t   job_o
);
  import lwf_pkg::*;

  logic [7:0] x, y, w, h;
  logic [8:0] col;
  logic [7:0] top;

  assign x = s_axis_tdata[7:0];
  assign y = s_axis_tdata[15:8];
  assign w = s_axis_tdata[23:16];
  assign h = s_axis_tdata[31:24];

  assign col = {2'b00, div3(x)} + {1'b0, col_offset_i};
  assign top = y + row_offset_i;

  assign s_axis_tready = !q_stat_i.full;
  assign push_o        = s_axis_tvalid && !q_stat_i.full;

  always_comb begin
    job_o.kind   = s_axis_tuser;
    job_o.col    = col;
    job_o.top    = top;
    job_o.right  = col[7:0] + {1'b0, div3(w)} - 8'd1;
    job_o.bottom = top + h - 8'd1;
    job_o.y      = y;
    job_o.pix    = s_axis_tdata[39:32];
  end

endmodule

[sv/lwf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window write formatter - job queue
// Small FIFO of classified jobs between front and back end.
// ----------------------------------------------------------------------------
module lwf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lwf_pkg::lwf_job_t    push_data_i,
  input  logic                 pop_i,
  output lwf_pkg::lwf_job_t    head_o,
  output lwf_pkg::lwf_q_stat_t stat_o
);
  import lwf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lwf_job_t          store_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = store_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

[sv/lwf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window write formatter - back end
// Walks the head job byte by byte into the output register.
// ----------------------------------------------------------------------------
module lwf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lwf_pkg::lwf_job_t    head_i,
  input  lwf_pkg::lwf_q_stat_t q_stat_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);
  import lwf_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] last_step;
  logic [7:0]        win_bytes [WIN_BYTES];
  logic [7:0]        cur_byte;
  logic              at_last, advance;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q;
  logic              out_cmd_q, out_last_q;

  always_comb begin
    win_bytes[0]  = CMD_COL_START;
    win_bytes[1]  = head_i.col[7:0];
    win_bytes[2]  = CMD_ROW_START;
    win_bytes[3]  = head_i.top;
    win_bytes[4]  = CMD_COL_END;
    win_bytes[5]  = head_i.right;
    win_bytes[6]  = CMD_ROW_END;
    win_bytes[7]  = head_i.bottom;
    win_bytes[8]  = CMD_WIN_ENABLE;
    win_bytes[9]  = {4'h0, head_i.col[3:0]};
    win_bytes[10] = CMD_COL_ADDR_HI | {3'b000, head_i.col[8:4]};
    win_bytes[11] = CMD_ROW_ADDR_LO + {4'h0, head_i.y[3:0]};
    win_bytes[12] = CMD_ROW_ADDR_HI + {4'h0, head_i.y[7:4]};
  end

  assign last_step = (head_i.kind == KIND_PIXEL) ? STEP_W'(PIX_BYTES - 1)
                                                 : STEP_W'(WIN_BYTES - 1);
  assign at_last   = (step_q == last_step);
  assign cur_byte  = (head_i.kind == KIND_PIXEL)
                   ? PAIR_MAP[head_i.pix[{step_q[1:0], 1'b0} +: 2]]
                   : win_bytes[step_q];

  assign advance = !q_stat_i.empty && (!out_valid_q || m_axis_tready);
  assign pop_o   = advance && at_last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      step_d      = at_last ? '0 : step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= cur_byte;
      out_cmd_q  <= (head_i.kind == KIND_WINDOW);
      out_last_q <= at_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_cmd_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[sv/lcd_window_write_formatter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window write formatter - top level
// Turns window requests and packed pixel bytes into controller byte streams.
// ----------------------------------------------------------------------------
// A window item (tuser = 0) becomes 13 command bytes, a pixel item (tuser = 1)
// becomes 4 data bytes, lowest bit pair first; tuser on the output marks
// command bytes and tlast the final byte of each item. The output runs at one
// byte per cycle, set by the back-end sequencer, while a job is queued and
// tready does not stall it; a QUEUE_DEPTH job queue lets the input keep
// taking items while earlier ones drain. Each item is registered in the queue,
// then its bytes in the output register. Offsets reset to 24 (column), 20 (row).
`include "lcd_window_write_formatter_unit_macros.svh"

module lcd_window_write_formatter_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // x_pixel, y_row, width_pixels, height_rows, pixel_byte
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tuser,  // is_command
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);
  import lwf_pkg::*;

  logic [7:0]  col_offset_q, row_offset_q;
  logic        push, pop;
  lwf_job_t    job, head;
  lwf_q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_offset_q <= COL_OFFSET_RESET;
      row_offset_q <= ROW_OFFSET_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_COLUMN_OFFSET) begin
        col_offset_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == REG_ROW_OFFSET) begin
        row_offset_q <= cfg_wdata_i;
      end
    end
  end

  lwf_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .col_offset_i  (col_offset_q),
    .row_offset_i  (row_offset_q),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .job_o         (job)
  );

  lwf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  lwf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `LWF_ASSERT(a_push_lands, (s_axis_tvalid && s_axis_tready) |=> !q_stat.empty)
  `LWF_ASSERT(a_item_no_gap, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
  `LWF_ASSERT_NEVER(a_no_push_when_full, push && q_stat.full)
  `LWF_ASSERT_NEVER(a_no_pop_when_empty, pop && q_stat.empty)

endmodule
